### src/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

    // Parser phase
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_STR     = 4'd1,
        PH_ESC     = 4'd2,
        PH_HEX1    = 4'd3,
        PH_PAIR_BS = 4'd4,
        PH_PAIR_U  = 4'd5,
        PH_HEX2    = 4'd6
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_NOTSTR = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_ESCAPE   = 3'd1;
    localparam logic [2:0] ERR_HEX      = 3'd2;
    localparam logic [2:0] ERR_EARLY    = 3'd3;
    localparam logic [2:0] ERR_CONTROL  = 3'd4;

    // Most results one input byte can cause
    localparam int MAX_RES = 6;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] err;
    } res_t;

    typedef struct packed {
        logic [2:0]        n;
        res_t [MAX_RES-1:0] r;
    } res_list_t;

    // UTF-8 bytes of one 16-bit code unit
    typedef struct packed {
        logic [1:0]       n;
        logic [2:0][7:0]  b;
    } enc_t;

    // Outcome of one string-content or escape byte
    typedef struct packed {
        logic   emit_en;
        res_t   res;
        phase_t ph;
        logic   go_idle;
        logic   start_hex;
    } step_t;

endpackage

`default_nettype wire

### src/json_string_unescape_utf8.sv
// JSON string unescaper. Feed the text one byte per beat, starting at the
// opening quote; the block returns the string content as UTF-8 data beats,
// resolving simple escapes and \uXXXX escapes (surrogate pairs become one
// 4-byte sequence), then a "string closed" beat at the closing quote. Bad
// escape letters, bad hex digits, raw bytes 0x07-0x0D and an early end of
// input give one error beat and return the block to idle. Each input byte is
// decoded in the cycle it is accepted and its 0 to 6 results land in a result
// buffer that drains one result per cycle unless out_stall; the block takes a
// new byte every cycle while out_stall is low and each byte gives at most one
// result. A byte that expands into more results holds the input off while the
// buffer drains. The last result of each input byte carries last = 1.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_input,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      out_byte,
    output logic [2:0]      error_code,
    output logic            last
);
    import jsu_pkg::*;

    phase_t         phase_reg, phase_next;
    logic [15:0]    first_reg, first_next;
    logic [15:0]    second_reg, second_next;
    logic [1:0]     cnt_reg, cnt_next;

    res_t [MAX_RES-1:0] buf_reg;
    logic [2:0]     fill_reg, fill_next;
    logic [2:0]     idx_reg, idx_next;

    res_list_t      lst;
    step_t          sb;
    logic           in_take;
    logic           out_take;
    logic           space;
    logic           hex_ok;
    logic [3:0]     hex_val;
    logic [15:0]    first_sh;
    logic [15:0]    second_sh;
    logic [20:0]    cp;

    function automatic res_t mk_res(logic [1:0] k, logic [7:0] d, logic [2:0] e);
        res_t o;
        o.kind = k;
        o.data = d;
        o.err  = e;
        return o;
    endfunction

    function automatic res_list_t push(res_list_t l, res_t r);
        res_list_t o;
        o = l;
        if (l.n < 3'(MAX_RES))
        begin
            o.r[l.n] = r;
            o.n      = l.n + 3'd1;
        end
        return o;
    endfunction

    function automatic enc_t encode_unit(logic [15:0] u);
        enc_t o;
        o = '0;
        if (u[15:7] == '0)
        begin
            o.n    = 2'd1;
            o.b[0] = {1'b0, u[6:0]};
        end
        else if (u[15:11] == '0)
        begin
            o.n    = 2'd2;
            o.b[0] = {3'b110, u[10:6]};
            o.b[1] = {2'b10, u[5:0]};
        end
        else
        begin
            o.n    = 2'd3;
            o.b[0] = {4'b1110, u[15:12]};
            o.b[1] = {2'b10, u[11:6]};
            o.b[2] = {2'b10, u[5:0]};
        end
        return o;
    endfunction

    function automatic res_list_t push_unit(res_list_t l, logic [15:0] u);
        res_list_t o;
        enc_t      e;
        o = l;
        e = encode_unit(u);
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < e.n)
                o = push(o, mk_res(KIND_DATA, e.b[i], ERR_NONE));
        end
        return o;
    endfunction

    function automatic logic is_high(logic [15:0] u);
        return u[15:10] == 6'b110110;
    endfunction

    function automatic logic is_low(logic [15:0] u);
        return u[15:10] == 6'b110111;
    endfunction

    // Ordinary string content byte
    function automatic step_t string_byte(logic [7:0] b);
        step_t o;
        o           = '0;
        o.emit_en   = 1'b1;
        o.res       = mk_res(KIND_DATA, b, ERR_NONE);
        o.ph        = PH_STR;
        if (b == "\"")
        begin
            o.res     = mk_res(KIND_CLOSED, 8'h00, ERR_NONE);
            o.ph      = PH_IDLE;
            o.go_idle = 1'b1;
        end
        else if (b == "\\")
        begin
            o.emit_en = 1'b0;
            o.ph      = PH_ESC;
        end
        else if (b inside {[8'h07:8'h0D]})
        begin
            o.res     = mk_res(KIND_ERROR, 8'h00, ERR_CONTROL);
            o.ph      = PH_IDLE;
            o.go_idle = 1'b1;
        end
        return o;
    endfunction

    // Letter after a backslash
    function automatic step_t escape_letter(logic [7:0] b);
        step_t o;
        o         = '0;
        o.emit_en = 1'b1;
        o.ph      = PH_STR;
        case (b)
            "n":  o.res = mk_res(KIND_DATA, 8'h0A, ERR_NONE);
            "r":  o.res = mk_res(KIND_DATA, 8'h0D, ERR_NONE);
            "t":  o.res = mk_res(KIND_DATA, 8'h09, ERR_NONE);
            "b":  o.res = mk_res(KIND_DATA, 8'h08, ERR_NONE);
            "f":  o.res = mk_res(KIND_DATA, 8'h0C, ERR_NONE);
            "/", "\\", "\"":
                  o.res = mk_res(KIND_DATA, b, ERR_NONE);
            "u":
            begin
                o.emit_en   = 1'b0;
                o.ph        = PH_HEX1;
                o.start_hex = 1'b1;
            end
            default:
            begin
                o.res     = mk_res(KIND_ERROR, 8'h00, ERR_ESCAPE);
                o.ph      = PH_IDLE;
                o.go_idle = 1'b1;
            end
        endcase
        return o;
    endfunction

    // Decode one hex digit
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte inside {["0":"9"]})
            hex_val = in_byte[3:0];
        else if (in_byte inside {["A":"F"], ["a":"f"]})
            hex_val = in_byte[3:0] + 4'd9;
        else
            hex_ok = 1'b0;
    end

    assign first_sh  = {first_reg[11:0], hex_val};
    assign second_sh = {second_reg[11:0], hex_val};
    assign cp        = 21'h10000 + {1'b0, first_reg[9:0], second_sh[9:0]};

    // Decode the accepted byte into its result list and the next state
    always_comb
    begin
        lst         = '0;
        sb          = '0;
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        cnt_next    = cnt_reg;

        if (end_of_input)
        begin
            if (phase_reg inside {[PH_STR:PH_HEX2]})
                lst = push(lst, mk_res(KIND_ERROR, 8'h00, ERR_EARLY));
            phase_next  = PH_IDLE;
            first_next  = '0;
            second_next = '0;
            cnt_next    = '0;
        end
        else
        begin
            case (phase_reg)
                PH_STR:
                begin
                    sb = string_byte(in_byte);
                end
                PH_ESC:
                begin
                    sb = escape_letter(in_byte);
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (!hex_ok)
                    begin
                        sb.emit_en = 1'b1;
                        sb.res     = mk_res(KIND_ERROR, 8'h00, ERR_HEX);
                        sb.ph      = PH_IDLE;
                        sb.go_idle = 1'b1;
                    end
                    else
                    begin
                        sb.ph = phase_reg;
                        if (phase_reg == PH_HEX1)
                            first_next = first_sh;
                        else
                            second_next = second_sh;
                        if (cnt_reg != 2'd3)
                            cnt_next = cnt_reg + 2'd1;
                        else
                        begin
                            cnt_next = '0;
                            if (phase_reg == PH_HEX2)
                            begin
                                if (is_low(second_sh))
                                begin
                                    lst = push(lst, mk_res(KIND_DATA,
                                        {5'b11110, cp[20:18]}, ERR_NONE));
                                    lst = push(lst, mk_res(KIND_DATA,
                                        {2'b10, cp[17:12]}, ERR_NONE));
                                    lst = push(lst, mk_res(KIND_DATA,
                                        {2'b10, cp[11:6]}, ERR_NONE));
                                    lst = push(lst, mk_res(KIND_DATA,
                                        {2'b10, cp[5:0]}, ERR_NONE));
                                    sb.ph = PH_STR;
                                end
                                else if (is_high(second_sh))
                                begin
                                    lst        = push_unit(lst, first_reg);
                                    first_next = second_sh;
                                    sb.ph      = PH_PAIR_BS;
                                end
                                else
                                begin
                                    lst   = push_unit(lst, first_reg);
                                    lst   = push_unit(lst, second_sh);
                                    sb.ph = PH_STR;
                                end
                            end
                            else if (is_high(first_sh))
                                sb.ph = PH_PAIR_BS;
                            else
                            begin
                                lst   = push_unit(lst, first_sh);
                                sb.ph = PH_STR;
                            end
                        end
                    end
                end
                PH_PAIR_BS:
                begin
                    if (in_byte == "\\")
                        sb.ph = PH_PAIR_U;
                    else
                    begin
                        lst = push_unit(lst, first_reg);
                        sb  = string_byte(in_byte);
                    end
                end
                PH_PAIR_U:
                begin
                    if (in_byte == "u")
                    begin
                        sb.ph       = PH_HEX2;
                        second_next = '0;
                        cnt_next    = '0;
                    end
                    else
                    begin
                        lst = push_unit(lst, first_reg);
                        sb  = escape_letter(in_byte);
                    end
                end
                default:
                begin
                    first_next  = '0;
                    second_next = '0;
                    cnt_next    = '0;
                    if (in_byte == "\"")
                        sb.ph = PH_STR;
                    else
                    begin
                        sb.emit_en = 1'b1;
                        sb.res     = mk_res(KIND_NOTSTR, 8'h00, ERR_NONE);
                        sb.ph      = PH_IDLE;
                    end
                end
            endcase

            // Apply the content or escape step
            if (sb.emit_en)
                lst = push(lst, sb.res);
            phase_next = sb.ph;
            if (sb.go_idle)
            begin
                first_next  = '0;
                second_next = '0;
                cnt_next    = '0;
            end
            if (sb.start_hex)
            begin
                first_next = '0;
                cnt_next   = '0;
            end
        end
    end

    // Handshakes: take a new byte once the buffer empties this cycle
    assign out_valid = idx_reg != fill_reg;
    assign out_take  = out_valid && !out_stall;
    assign space     = !out_valid || (out_take && (idx_reg + 3'd1 == fill_reg));
    assign in_stall  = !space;
    assign in_take   = in_valid && space;

    // Advance the buffer read index or load a new result list
    always_comb
    begin
        fill_next = fill_reg;
        idx_next  = idx_reg;
        if (in_take)
        begin
            fill_next = lst.n;
            idx_next  = '0;
        end
        else if (out_take)
            idx_next = idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            first_reg  <= '0;
            second_reg <= '0;
            cnt_reg    <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
            if (in_take)
            begin
                phase_reg  <= phase_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

    // Hold the result list of the accepted byte
    always_ff @(posedge clk)
    begin
        if (in_take)
            buf_reg <= lst.r;
    end

    // Drive the current result
    assign kind       = buf_reg[idx_reg].kind;
    assign out_byte   = buf_reg[idx_reg].data;
    assign error_code = buf_reg[idx_reg].err;
    assign last       = idx_reg + 3'd1 == fill_reg;

endmodule

`default_nettype wire

### src/jsu_checker.sv
`default_nettype none

module jsu_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] in_byte,
    input wire logic       end_of_input,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] kind,
    input wire logic [7:0] out_byte,
    input wire logic [2:0] error_code,
    input wire logic       last
);
    import jsu_pkg::*;

    // Hold a stalled input beat
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(end_of_input))
        else $error("stalled input beat changed");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte)
            && $stable(error_code) && $stable(last))
        else $error("stalled result beat changed");

    // Close, not-a-string and error beats end the results of their byte
    a_final_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> last)
        else $error("non-data result not marked last");

    // Error beats carry a known code, other beats carry none
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_ERROR) == (error_code == ERR_ESCAPE
            || error_code == ERR_HEX || error_code == ERR_EARLY
            || error_code == ERR_CONTROL))
        else $error("error code does not match result kind");

    // Non-data beats carry a zero byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> out_byte == 8'h00)
        else $error("non-data result carries a byte");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
    import jsu_pkg::*;

    // Characters the parser treats specially
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = "u";
    localparam logic [7:0] SIMPLE_ESC [8] = '{"n", "r", "t", "b", "f", "/", CH_BSLASH, CH_QUOTE};

    localparam int STALL_PCT   = 13;
    localparam int BYTE_TARGET = 390;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 20;

    // How a stimulus row gets its expectation
    typedef enum logic [1:0] {
        ROW_PRED = 2'd0,
        ROW_ONE  = 2'd1,
        ROW_NONE = 2'd2
    } row_mode_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
        row_mode_t  mode;
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] err;
    } row_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] err;
        logic       last;
    } utf8_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_input = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last;

    json_string_unescape_utf8 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .out_byte     (out_byte),
        .error_code   (error_code),
        .last         (last)
    );

    // Predictor state
    phase_t      ph = PH_IDLE;
    logic [15:0] unit_a = 16'h0000;
    logic [15:0] unit_b = 16'h0000;
    logic [1:0]  digits = 2'd0;
    utf8_beat_t  byte_results [$];

    utf8_beat_t  due_beats [$];
    row_t        row_q [$];
    row_t        text_q [$];
    row_t        plan [0:32];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic void put_result(input logic [1:0] k, input logic [7:0] d,
                                       input logic [2:0] e);
        if (byte_results.size() < MAX_RES)
            byte_results.push_back('{k, d, e, 1'b0});
    endfunction

    function automatic void to_idle();
        ph = PH_IDLE;
        unit_a = 16'h0000;
        unit_b = 16'h0000;
        digits = 2'd0;
    endfunction

    function automatic void raise_error(input logic [2:0] e);
        put_result(KIND_ERROR, 8'h00, e);
        to_idle();
    endfunction

    function automatic bit is_high(input logic [15:0] u);
        return u >= 16'hD800 && u <= 16'hDBFF;
    endfunction

    function automatic bit is_low(input logic [15:0] u);
        return u >= 16'hDC00 && u <= 16'hDFFF;
    endfunction

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9")
            return int'(b - "0");
        if (b >= "A" && b <= "F")
            return int'(b - "A") + 10;
        if (b >= "a" && b <= "f")
            return int'(b - "a") + 10;
        return -1;
    endfunction

    function automatic void put_utf8(input logic [20:0] cp);
        if (cp <= 21'h7F)
        begin
            put_result(KIND_DATA, cp[7:0], ERR_NONE);
        end
        else if (cp <= 21'h7FF)
        begin
            put_result(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE);
            put_result(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
        end
        else if (cp <= 21'hFFFF)
        begin
            put_result(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE);
            put_result(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
            put_result(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
        end
        else
        begin
            put_result(KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE);
            put_result(KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE);
            put_result(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
            put_result(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
        end
    endfunction

    function automatic void content_byte(input logic [7:0] b);
        if (b == CH_QUOTE)
        begin
            put_result(KIND_CLOSED, 8'h00, ERR_NONE);
            to_idle();
        end
        else if (b == CH_BSLASH)
            ph = PH_ESC;
        else if (b >= 8'h07 && b <= 8'h0D)
            raise_error(ERR_CONTROL);
        else
            put_result(KIND_DATA, b, ERR_NONE);
    endfunction

    function automatic void escape_letter(input logic [7:0] b);
        logic [7:0] v;
        case (b)
            "n": v = 8'h0A;
            "r": v = 8'h0D;
            "t": v = 8'h09;
            "b": v = 8'h08;
            "f": v = 8'h0C;
            "/", CH_BSLASH, CH_QUOTE: v = b;
            CH_U:
            begin
                ph = PH_HEX1;
                unit_a = 16'h0000;
                digits = 2'd0;
                return;
            end
            default:
            begin
                raise_error(ERR_ESCAPE);
                return;
            end
        endcase
        put_result(KIND_DATA, v, ERR_NONE);
        ph = PH_STR;
    endfunction

    // Join, pair up or flush a finished second code unit
    function automatic void second_unit_done(input logic [15:0] u);
        if (is_low(u))
        begin
            put_utf8(21'h10000 + {1'b0, unit_a[9:0], u[9:0]});
            ph = PH_STR;
        end
        else if (is_high(u))
        begin
            put_utf8({5'd0, unit_a});
            unit_a = u;
            ph = PH_PAIR_BS;
        end
        else
        begin
            put_utf8({5'd0, unit_a});
            put_utf8({5'd0, u});
            ph = PH_STR;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eoi);
        int d;
        byte_results.delete();
        if (eoi)
        begin
            if (ph != PH_IDLE)
                put_result(KIND_ERROR, 8'h00, ERR_EARLY);
            to_idle();
        end
        else
        begin
            case (ph)
                PH_STR: content_byte(b);
                PH_ESC: escape_letter(b);
                PH_HEX1, PH_HEX2:
                begin
                    d = hex_digit(b);
                    if (d < 0)
                        raise_error(ERR_HEX);
                    else
                    begin
                        if (ph == PH_HEX1)
                            unit_a = {unit_a[11:0], d[3:0]};
                        else
                            unit_b = {unit_b[11:0], d[3:0]};
                        if (digits < 2'd3)
                            digits = digits + 2'd1;
                        else
                        begin
                            digits = 2'd0;
                            if (ph == PH_HEX2)
                                second_unit_done(unit_b);
                            else if (is_high(unit_a))
                                ph = PH_PAIR_BS;
                            else
                            begin
                                put_utf8({5'd0, unit_a});
                                ph = PH_STR;
                            end
                        end
                    end
                end
                PH_PAIR_BS:
                begin
                    if (b == CH_BSLASH)
                        ph = PH_PAIR_U;
                    else
                    begin
                        put_utf8({5'd0, unit_a});
                        ph = PH_STR;
                        content_byte(b);
                    end
                end
                PH_PAIR_U:
                begin
                    if (b == CH_U)
                    begin
                        ph = PH_HEX2;
                        unit_b = 16'h0000;
                        digits = 2'd0;
                    end
                    else
                    begin
                        put_utf8({5'd0, unit_a});
                        ph = PH_STR;
                        escape_letter(b);
                    end
                end
                default:
                begin
                    if (b == CH_QUOTE)
                    begin
                        to_idle();
                        ph = PH_STR;
                    end
                    else
                    begin
                        put_result(KIND_NOTSTR, 8'h00, ERR_NONE);
                        to_idle();
                    end
                end
            endcase
        end
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Predict each accepted input beat, then check each accepted result beat
    always @(posedge clk)
    begin : check_proc
        row_t       row;
        utf8_beat_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                row = row_q.pop_front();
                decode_byte(in_byte, end_of_input);
                case (row.mode)
                    ROW_ONE: due_beats.push_back('{row.kind, row.data, row.err, 1'b1});
                    ROW_NONE: ;
                    default:
                        foreach (byte_results[i])
                            due_beats.push_back(byte_results[i]);
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (due_beats.size() == 0)
                    report_mismatch("result beat with nothing outstanding, kind", kind, 0);
                else
                begin
                    want = due_beats.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", kind, want.kind);
                    if (out_byte !== want.data)
                        report_mismatch("out_byte", out_byte, want.data);
                    if (error_code !== want.err)
                        report_mismatch("error_code", error_code, want.err);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Stall the result side at random, except in the calm stretch
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < STALL_PCT);

    // ---------------------------------------------------------------- stimulus

    task automatic send_beat(input row_t r);
        while (!calm && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        row_q.push_back(r);
        in_valid     <= 1'b1;
        in_byte      <= r.b;
        end_of_input <= r.eoi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_beats.size() != 0)
            @(posedge clk);
    endtask

    function automatic void push_byte(input logic [7:0] b, input logic eoi = 1'b0);
        text_q.push_back('{b, eoi, ROW_PRED, 2'd0, 8'h00, 3'd0});
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        if ($urandom_range(1))
            return "a" + {4'h0, n} - 8'd10;
        return "A" + {4'h0, n} - 8'd10;
    endfunction

    function automatic void push_unit(input logic [15:0] u);
        push_byte(CH_BSLASH);
        push_byte(CH_U);
        for (int i = 3; i >= 0; i--)
            push_byte(hex_char(u[i*4 +: 4]));
    endfunction

    // Code unit classes: 0 one byte, 1 two bytes, 2 three bytes, 3 high, 4 low
    function automatic logic [15:0] pick_unit(input int cls);
        case (cls)
            0: return 16'($urandom_range(16'h007F, 16'h0000));
            1: return 16'($urandom_range(16'h07FF, 16'h0080));
            2:
            begin
                if ($urandom_range(1))
                    return 16'($urandom_range(16'hD7FF, 16'h0800));
                return 16'($urandom_range(16'hFFFF, 16'hE000));
            end
            3: return 16'($urandom_range(16'hDBFF, 16'hD800));
            default: return 16'($urandom_range(16'hDFFF, 16'hDC00));
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_QUOTE || b == CH_BSLASH || (b >= 8'h07 && b <= 8'h0D));
        return b;
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] b);
        foreach (SIMPLE_ESC[i])
            if (b == SIMPLE_ESC[i])
                return 1'b1;
        return b == CH_U;
    endfunction

    // Append one broken piece that drops the block back to idle
    function automatic void push_fault();
        logic [7:0] b;
        case ($urandom_range(3))
            0:
            begin
                do
                    b = 8'($urandom_range(255));
                while (is_escape_letter(b));
                push_byte(CH_BSLASH);
                push_byte(b);
            end
            1:
            begin
                if ($urandom_range(1))
                    push_unit(pick_unit(3));
                push_byte(CH_BSLASH);
                push_byte(CH_U);
                repeat ($urandom_range(3))
                    push_byte(hex_char(4'($urandom_range(15))));
                do
                    b = 8'($urandom_range(255));
                while (hex_digit(b) >= 0);
                push_byte(b);
            end
            2: push_byte(8'($urandom_range(8'h0D, 8'h07)));
            default: push_byte(8'($urandom_range(255)), 1'b1);
        endcase
    endfunction

    // Build one string with random content, or a little noise outside one
    function automatic void build_text();
        if ($urandom_range(99) < 8)
        begin
            repeat ($urandom_range(3, 1))
                push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            return;
        end
        push_byte(CH_QUOTE);
        repeat ($urandom_range(10))
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: push_byte(plain_char());
                9, 10, 11:
                begin
                    push_byte(CH_BSLASH);
                    push_byte(SIMPLE_ESC[$urandom_range(7)]);
                end
                12, 13: push_unit(pick_unit($urandom_range(2)));
                14:
                begin
                    push_unit(pick_unit(3));
                    push_unit(pick_unit(4));
                end
                15: push_unit(pick_unit(3));
                16:
                begin
                    push_unit(pick_unit(3));
                    push_byte(CH_BSLASH);
                    push_byte(SIMPLE_ESC[$urandom_range(7)]);
                end
                17:
                begin
                    push_unit(pick_unit(3));
                    push_unit(pick_unit($urandom_range(3)));
                end
                18: push_unit(pick_unit(4));
                default:
                begin
                    push_fault();
                    return;
                end
            endcase
        end
        if ($urandom_range(9) == 0)
            push_byte(8'($urandom_range(255)), 1'b1);
        else
            push_byte(CH_QUOTE);
    endfunction

    initial
    begin
        int items;
        int text_no;

        plan = '{
            // outside a string
            '{8'hFF,     1'b0, ROW_ONE,  KIND_NOTSTR, 8'h00, ERR_NONE},
            '{8'h00,     1'b0, ROW_ONE,  KIND_NOTSTR, 8'h00, ERR_NONE},
            '{8'h00,     1'b1, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            // raw content extremes, question mark, control byte
            '{CH_QUOTE,  1'b0, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            '{8'h00,     1'b0, ROW_ONE,  KIND_DATA,   8'h00, ERR_NONE},
            '{8'hFF,     1'b0, ROW_ONE,  KIND_DATA,   8'hFF, ERR_NONE},
            '{"?",       1'b0, ROW_ONE,  KIND_DATA,   "?",   ERR_NONE},
            '{8'h07,     1'b0, ROW_ONE,  KIND_ERROR,  8'h00, ERR_CONTROL},
            // unknown escape letter
            '{CH_QUOTE,  1'b0, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            '{CH_BSLASH, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            '{"q",       1'b0, ROW_ONE,  KIND_ERROR,  8'h00, ERR_ESCAPE},
            // bad hex digit
            '{CH_QUOTE,  1'b0, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            '{CH_BSLASH, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            '{CH_U,      1'b0, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            '{"g",       1'b0, ROW_ONE,  KIND_ERROR,  8'h00, ERR_HEX},
            // surrogate pair joined into four bytes
            '{CH_QUOTE,  1'b0, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            '{CH_BSLASH, 1'b0, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            '{CH_U,      1'b0, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            '{"D",       1'b0, ROW_PRED, KIND_DATA,   8'h00, ERR_NONE},
            '{"8",       1'b0, ROW_PRED, KIND_DATA,   8'h00, ERR_NONE},
            '{"3",       1'b0, ROW_PRED, KIND_DATA,   8'h00, ERR_NONE},
            '{"d",       1'b0, ROW_PRED, KIND_DATA,   8'h00, ERR_NONE},
            '{CH_BSLASH, 1'b0, ROW_PRED, KIND_DATA,   8'h00, ERR_NONE},
            '{CH_U,      1'b0, ROW_PRED, KIND_DATA,   8'h00, ERR_NONE},
            '{"D",       1'b0, ROW_PRED, KIND_DATA,   8'h00, ERR_NONE},
            '{"e",       1'b0, ROW_PRED, KIND_DATA,   8'h00, ERR_NONE},
            '{"0",       1'b0, ROW_PRED, KIND_DATA,   8'h00, ERR_NONE},
            '{"0",       1'b0, ROW_PRED, KIND_DATA,   8'h00, ERR_NONE},
            '{8'h0D,     1'b0, ROW_ONE,  KIND_ERROR,  8'h00, ERR_CONTROL},
            // early end, then an empty string
            '{CH_QUOTE,  1'b0, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            '{8'hA5,     1'b1, ROW_ONE,  KIND_ERROR,  8'h00, ERR_EARLY},
            '{CH_QUOTE,  1'b0, ROW_NONE, KIND_DATA,   8'h00, ERR_NONE},
            '{CH_QUOTE,  1'b0, ROW_ONE,  KIND_CLOSED, 8'h00, ERR_NONE}
        };

        // hold reset, then release
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        foreach (plan[i])
            send_beat(plan[i]);

        // random strings; one calm stretch and periodic full drains
        items = 0;
        text_no = 0;
        while (items < BYTE_TARGET)
        begin
            calm = (text_no >= 8 && text_no < 13);
            build_text();
            while (text_q.size() != 0)
            begin
                send_beat(text_q.pop_front());
                items++;
            end
            if (text_no % 10 == 4)
                wait_drained();
            text_no++;
        end
        calm = 1'b0;

        // drain and let any stray beats show up
        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
src/jsu_pkg.sv
src/json_string_unescape_utf8.sv
src/jsu_checker.sv
tb/tb.sv
